// ----- rtl/core/abmsd_pkg.sv -----
// Shared types and constants for the ADC burst mean and deviation block.
`default_nettype none

package abmsd_pkg;

	// Field widths fixed by the result format
	localparam int unsigned CHAN_W   = 3;
	localparam int unsigned CTRL_W   = 8;
	localparam int unsigned MEAN_W   = 12;
	localparam int unsigned STDEV_W  = 11;
	localparam int unsigned REPLY_W  = 8;

	// Conversion command base and the last sample index of a burst
	localparam logic [CTRL_W-1:0] CMD_BASE   = 8'h8f;
	localparam logic [1:0]        BURST_LAST = 2'd3;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic acc;     // take the accepted sample into the sums
		logic square;  // register sum * sum
		logic diff;    // form the radicand, seed the root
		logic root;    // one square root step
		logic load;    // fill the output register, clear the sums
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic root_done;  // current root step is the last one
	} status_t;

endpackage

`default_nettype wire

// ----- rtl/core/adc_burst_mean_stdev_top.sv -----
// Top level of the ADC burst mean and standard deviation block.
`default_nettype none

// Takes one serial ADC conversion per sample beat (channel plus the two reply
// bytes), unpacks the top SAMPLE_BITS bits as the sample and sums four samples
// to a burst. After the fourth it gives one result beat: the channel of that
// fourth sample, its command byte 0x8f | channel<<4, the mean in quarter LSB
// (the burst sum) and the population standard deviation in quarter LSB
// (floor of the root of 4*sumsq - sum*sum). Outputs wider than a field are cut
// to the field. The first three samples of a burst are taken back to back;
// after the fourth the input stalls while the block squares the sum, forms the
// radicand, runs SAMPLE_BITS+2 square root steps that resolve one result bit
// each and loads the output register. The result sits in that register, so
// the next burst streams in while it waits to be taken; the load stalls only
// if an earlier result is still untaken when the next is ready.
module adc_burst_mean_stdev_top #(
	parameter int unsigned SAMPLE_BITS = 10
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             sample_valid,
	output      logic                             sample_stall,
	input  wire logic [abmsd_pkg::CHAN_W-1:0]     channel,
	input  wire logic [abmsd_pkg::REPLY_W-1:0]    reply_high,
	input  wire logic [abmsd_pkg::REPLY_W-1:0]    reply_low,
	output      logic                             result_valid,
	input  wire logic                             result_stall,
	output      logic [abmsd_pkg::CHAN_W-1:0]     channel_out,
	output      logic [abmsd_pkg::CTRL_W-1:0]     control_byte,
	output      logic [abmsd_pkg::MEAN_W-1:0]     mean_quarter,
	output      logic [abmsd_pkg::STDEV_W-1:0]    stdev_quarter
);
	import abmsd_pkg::*;

	cmd_t    cmd;
	status_t status;

	abmsd_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd),
		.status       (status)
	);

	abmsd_datapath #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.channel       (channel),
		.reply_high    (reply_high),
		.reply_low     (reply_low),
		.channel_out   (channel_out),
		.control_byte  (control_byte),
		.mean_quarter  (mean_quarter),
		.stdev_quarter (stdev_quarter)
	);

endmodule

`default_nettype wire

// ----- rtl/core/abmsd_datapath.sv -----
// Datapath: sample unpack, running sums, variance term, digit-pair square root, output register.
`default_nettype none

module abmsd_datapath #(
	parameter int unsigned SAMPLE_BITS = 10
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire abmsd_pkg::cmd_t                  cmd,
	output      abmsd_pkg::status_t               status,
	input  wire logic [abmsd_pkg::CHAN_W-1:0]     channel,
	input  wire logic [abmsd_pkg::REPLY_W-1:0]    reply_high,
	input  wire logic [abmsd_pkg::REPLY_W-1:0]    reply_low,
	output      logic [abmsd_pkg::CHAN_W-1:0]     channel_out,
	output      logic [abmsd_pkg::CTRL_W-1:0]     control_byte,
	output      logic [abmsd_pkg::MEAN_W-1:0]     mean_quarter,
	output      logic [abmsd_pkg::STDEV_W-1:0]    stdev_quarter
);
	import abmsd_pkg::*;

	localparam int unsigned SW = SAMPLE_BITS + 2;
	localparam int unsigned QW = 2 * SAMPLE_BITS + 2;
	localparam int unsigned RW = 2 * SAMPLE_BITS + 4;
	localparam int unsigned PW = 2 * SAMPLE_BITS;

	logic [2*REPLY_W-1:0]     word;
	logic [SAMPLE_BITS-1:0]   sample;
	logic [2*SAMPLE_BITS-1:0] sample_sqr;
	logic [RW-1:0]            sum_sqr;
	logic [RW-1:0]            four_sq;
	logic [RW-1:0]            trial;

	logic [SW-1:0]     sum_q;
	logic [QW-1:0]     sq_q;
	logic [RW-1:0]     sumsq_q;
	logic [RW-1:0]     rad_q;
	logic [RW-1:0]     res_q;
	logic [RW-1:0]     bit_q;
	logic [CHAN_W-1:0] chan_q;

	logic [CHAN_W-1:0]  chan_out_q;
	logic [CTRL_W-1:0]  ctrl_q;
	logic [MEAN_W-1:0]  mean_q;
	logic [STDEV_W-1:0] stdev_q;

	// Unpack the sample from the top bits of the reply word
	assign word       = {reply_high, reply_low};
	assign sample     = word[2*REPLY_W-1 -: SAMPLE_BITS];
	assign sample_sqr = PW'(sample) * PW'(sample);
	assign sum_sqr    = RW'(sum_q) * RW'(sum_q);
	assign four_sq    = {sq_q, 2'b00};
	assign trial      = res_q + bit_q;

	assign status.root_done = bit_q[0];

	// Accumulate the burst sums; clear them once the result is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			sq_q  <= '0;
		end else if (cmd.load) begin
			sum_q <= '0;
			sq_q  <= '0;
		end else if (cmd.acc) begin
			sum_q <= sum_q + SW'(sample);
			sq_q  <= sq_q + QW'(sample_sqr);
		end
	end

	// Hold the channel of the latest sample
	always_ff @(posedge clk) begin
		if (cmd.acc) begin
			chan_q <= channel;
		end
	end

	// Variance term and square root, two radicand bits per step
	always_ff @(posedge clk) begin
		if (cmd.square) begin
			sumsq_q <= sum_sqr;
		end
		if (cmd.diff) begin
			rad_q <= (four_sq >= sumsq_q) ? four_sq - sumsq_q : '0;
			res_q <= '0;
			bit_q <= {2'b01, {(RW-2){1'b0}}};
		end else if (cmd.root) begin
			if (rad_q >= trial) begin
				rad_q <= rad_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			chan_out_q <= chan_q;
			ctrl_q     <= CMD_BASE | {1'b0, chan_q, 4'b0000};
			mean_q     <= MEAN_W'(sum_q);
			stdev_q    <= STDEV_W'(res_q);
		end
	end

	assign channel_out   = chan_out_q;
	assign control_byte  = ctrl_q;
	assign mean_quarter  = mean_q;
	assign stdev_quarter = stdev_q;

endmodule

`default_nettype wire

// ----- rtl/core/abmsd_ctrl.sv -----
// Controller: burst counter, sequencing state machine and output handshake.
`default_nettype none

module abmsd_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 sample_valid,
	output      logic                 sample_stall,
	output      logic                 result_valid,
	input  wire logic                 result_stall,
	output      abmsd_pkg::cmd_t      cmd,
	input  wire abmsd_pkg::status_t   status
);
	import abmsd_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SQUARE = 3'd1;
	localparam logic [2:0] S_DIFF   = 3'd2;
	localparam logic [2:0] S_ROOT   = 3'd3;
	localparam logic [2:0] S_EMIT   = 3'd4;

	logic [2:0] state_q;
	logic [1:0] cnt_q;
	logic       res_valid_q;
	logic       accept;
	logic       out_free;

	assign sample_stall = (state_q != S_IDLE);
	assign accept       = sample_valid && (state_q == S_IDLE);
	assign out_free     = !res_valid_q || !result_stall;
	assign result_valid = res_valid_q;

	// Decode datapath commands from the state
	always_comb begin
		cmd        = '0;
		cmd.acc    = accept;
		cmd.square = (state_q == S_SQUARE);
		cmd.diff   = (state_q == S_DIFF);
		cmd.root   = (state_q == S_ROOT);
		cmd.load   = (state_q == S_EMIT) && out_free;
	end

	// Advance the sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q <= cnt_q + 2'd1;
						if (cnt_q == BURST_LAST) begin
							state_q <= S_SQUARE;
						end
					end
				end
				S_SQUARE: state_q <= S_DIFF;
				S_DIFF:   state_q <= S_ROOT;
				S_ROOT: begin
					if (status.root_done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.load) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire
